// ===== src/cfq_pkg.sv =====
// Package for the circular FIFO queue: ring depth, request and status codes,
// result kinds and the command and status structs between controller and datapath.
// Depends on nothing.
package cfq_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [1:0] REQ_INS  = 2'd0;
	localparam logic [1:0] REQ_REM  = 2'd1;
	localparam logic [1:0] REQ_DISP = 2'd2;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	// Kind of result loaded into the output register.
	localparam logic [1:0] RES_INS   = 2'd0;
	localparam logic [1:0] RES_EMPTY = 2'd1;
	localparam logic [1:0] RES_WORD  = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;

	typedef struct packed {
		logic       ins;          // accepted insert
		logic       load;         // load the output register
		logic [1:0] kind;         // result kind
		logic       last;         // last flag for a word result
		logic       cur_head;     // cursor takes the head index
		logic       cur_advance;  // cursor moves to the next slot
		logic       pop;          // retire the head word
	} dp_cmd_t;

	typedef struct packed {
		logic empty;
		logic cur_at_tail;
		logic out_free;
	} dp_stat_t;

	function automatic idx_t next_idx(input idx_t i);
		return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
	endfunction

endpackage

// ===== src/cfq_ctrl.sv =====
// Controller of the circular FIFO queue: accepts requests and sequences the
// remove and display streams. Depends on cfq_pkg.
module cfq_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       req_type,
	input  cfq_pkg::dp_stat_t stat,
	output cfq_pkg::dp_cmd_t  cmd
);
	import cfq_pkg::*;

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_STREAM = 1'b1;

	logic state_q, state_d;
	logic op_rem_q, op_rem_d;
	logic accept;

	assign in_ready = (state_q == S_IDLE) && stat.out_free;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		op_rem_d = op_rem_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (req_type)
						REQ_INS: begin
							cmd.ins  = 1'b1;
							cmd.load = 1'b1;
							cmd.kind = RES_INS;
						end
						REQ_REM, REQ_DISP: begin
							if (stat.empty) begin
								cmd.load = 1'b1;
								cmd.kind = RES_EMPTY;
							end else begin
								cmd.cur_head = 1'b1;
								op_rem_d     = (req_type == REQ_REM);
								state_d      = S_STREAM;
							end
						end
						default: ;
					endcase
				end
			end
			S_STREAM: begin
				if (stat.out_free) begin
					cmd.load = 1'b1;
					cmd.kind = RES_WORD;
					cmd.last = op_rem_q || stat.cur_at_tail;
					if (op_rem_q) begin
						cmd.pop = 1'b1;
						state_d = S_IDLE;
					end else if (stat.cur_at_tail) begin
						state_d = S_IDLE;
					end else begin
						cmd.cur_advance = 1'b1;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			op_rem_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			op_rem_q <= op_rem_d;
		end
	end

	// A stream only ever runs over a ring that holds words.
	a_stream_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_STREAM) |-> !stat.empty)
		else $error("stream running on an empty ring");

	a_enter_stream: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !stat.empty && (req_type == REQ_REM || req_type == REQ_DISP))
		|=> (state_q == S_STREAM))
		else $error("remove or display did not start a stream");

endmodule

// ===== src/cfq_dp.sv =====
// Datapath of the circular FIFO queue: ring memory, head, tail and cursor
// indices, empty flag and the output register. Depends on cfq_pkg.
module cfq_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic signed [31:0]  value_in,
	input  cfq_pkg::dp_cmd_t    cmd,
	output cfq_pkg::dp_stat_t   stat,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  value_out,
	output logic [1:0]          status,
	output logic                last
);
	import cfq_pkg::*;

	logic signed [31:0] mem_q [DEPTH];
	logic signed [31:0] rdata_q;

	idx_t head_q, tail_q, cur_q, cur_d;
	logic empty_q;
	logic full;
	logic wr_en;
	idx_t wr_addr;

	logic               out_valid_q;
	logic signed [31:0] value_q;
	logic [1:0]         status_q;
	logic               last_q;

	assign full    = !empty_q && (next_idx(tail_q) == head_q);
	assign wr_en   = cmd.ins && !full;
	assign wr_addr = empty_q ? '0 : next_idx(tail_q);

	always_comb begin
		cur_d = cur_q;
		if (cmd.cur_head) begin
			cur_d = head_q;
		end else if (cmd.cur_advance) begin
			cur_d = next_idx(cur_q);
		end
	end

	assign stat.empty       = empty_q;
	assign stat.cur_at_tail = (cur_q == tail_q);
	assign stat.out_free    = !out_valid_q || out_ready;

	// The read register always follows the cursor, so it holds the word at
	// the cursor while a stream waits on the output.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= value_in;
		end
		rdata_q <= mem_q[cur_d];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			cur_q   <= '0;
			empty_q <= 1'b1;
		end else begin
			cur_q <= cur_d;
			if (wr_en) begin
				tail_q  <= wr_addr;
				empty_q <= 1'b0;
				if (empty_q) begin
					head_q <= '0;
				end
			end else if (cmd.pop) begin
				if (head_q == tail_q) begin
					head_q  <= '0;
					tail_q  <= '0;
					empty_q <= 1'b1;
				end else begin
					head_q <= next_idx(head_q);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			case (cmd.kind)
				RES_INS: begin
					value_q  <= '0;
					status_q <= full ? ST_FULL : ST_OK;
					last_q   <= 1'b1;
				end
				RES_EMPTY: begin
					value_q  <= '0;
					status_q <= ST_EMPTY;
					last_q   <= 1'b1;
				end
				RES_WORD: begin
					value_q  <= rdata_q;
					status_q <= ST_OK;
					last_q   <= cmd.last;
				end
				default: begin
					value_q  <= '0;
					status_q <= ST_OK;
					last_q   <= 1'b1;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign value_out = value_q;
	assign status    = status_q;
	assign last      = last_q;

	// A result still waiting for its taker must never be overwritten.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.load && out_valid_q) |-> out_ready)
		else $error("output register overwritten before it was taken");

	a_empty_idx: assert property (@(posedge clk) disable iff (!arst_n)
		empty_q |-> (head_q == '0 && tail_q == '0))
		else $error("empty ring with non-zero indices");

	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cur_advance |-> (cur_q != tail_q))
		else $error("display cursor advanced past the tail");

endmodule

// ===== src/circular_fifo_queue.sv =====
// Circular FIFO queue of signed 32-bit words in a ring of cfq_pkg::DEPTH entries.
// Insert: result the cycle after the beat; a new request every cycle while output is free.
// Remove: head word is read, then emitted once the output is free; next request waits.
// Display of n words: head word read first, then one word a cycle while output is free.
// Reset: indices to zero, queue empty, output register empty; the ring store is not cleared.
// Depends on cfq_pkg, cfq_ctrl and cfq_dp.
module circular_fifo_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic signed [31:0] value_in,
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [31:0] value_out,
	output logic [1:0]         status,
	output logic               last
);
	import cfq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	cfq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.req_type (req_type),
		.stat     (stat),
		.cmd      (cmd)
	);

	cfq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.value_in  (value_in),
		.cmd       (cmd),
		.stat      (stat),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.value_out (value_out),
		.status    (status),
		.last      (last)
	);

endmodule
